// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the steering controller modules.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/lls_pkg.sv =====
// Package for the lookahead lateral steering controller.
// Types, register codes and constants; depends on nothing.
`timescale 1ns / 1ps
package lls_pkg;
    localparam int MAX_POINTS_DEF = 1024;
    localparam logic [24:0] ONE_Q16 = 25'd65536;

    typedef enum logic [2:0] {
        REG_MIN_LA   = 3'd0,
        REG_MAX_LA   = 3'd1,
        REG_RATIO    = 3'd2,
        REG_GAIN     = 3'd3,
        REG_WBASE    = 3'd4,
        REG_SRATIO   = 3'd5,
        REG_INVERT   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [24:0] gain;
        logic [20:0] wheel_base;
        logic [22:0] steer_ratio;
        logic        invert;
    } back_cfg_t;

    typedef struct packed {
        logic signed [31:0] lateral;
        logic signed [31:0] chosen;
        logic [9:0]         index;
        logic [24:0]        speed;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV,
        ST_MUL_D,
        ST_DONE
    } back_state_t;
endpackage

// ===== rtl/lls_front.sv =====
// Front part: accepts path points, tracks lookahead search, emits one job per path.
// Depends on lls_pkg.
`timescale 1ns / 1ps
module lls_front #(
    parameter int MAX_POINTS = lls_pkg::MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic [24:0]        speed,
    input  logic               last_point,
    input  logic [24:0]        min_la,
    input  logic [24:0]        max_la,
    input  logic [24:0]        ratio,
    output logic               job_valid,
    input  logic               job_ready,
    output lls_pkg::job_t      job
);
    localparam int CAP_I = (MAX_POINTS - 1) < 1023 ? (MAX_POINTS - 1) : 1023;
    localparam logic [9:0] IDX_CAP = CAP_I[9:0];

    logic               start_reg, start_next;
    logic               found_reg, found_next;
    logic [24:0]        speed_reg, speed_next;
    logic [24:0]        dist_reg, dist_next;
    logic signed [31:0] first_reg, first_next;
    logic signed [31:0] chosen_reg, chosen_next;
    logic [9:0]         cnt_reg, cnt_next;
    logic [9:0]         cidx_reg, cidx_next;
    logic               jv_reg, jv_next;
    lls_pkg::job_t      job_reg, job_next;

    logic               accept;
    logic [49:0]        prod;
    logic [33:0]        d_raw;
    logic [24:0]        d_cl;
    logic [24:0]        dist_use;
    logic [9:0]         cnt_use;
    logic               found_use;
    logic               hit;

    assign in_ready  = !jv_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_comb
    begin
        prod  = {25'd0, speed} * {25'd0, ratio};
        d_raw = prod[49:16];
        d_cl  = (d_raw > {9'd0, max_la}) ? max_la : d_raw[24:0];
        if (d_cl < min_la)
        begin
            d_cl = min_la;
        end
        dist_use  = start_reg ? d_cl : dist_reg;
        cnt_use   = start_reg ? 10'd0 : cnt_reg;
        found_use = start_reg ? 1'b0 : found_reg;
        hit = !found_use && ($signed({point_x[31], point_x}) > $signed({8'd0, dist_use}));

        start_next  = start_reg;
        found_next  = found_reg;
        speed_next  = speed_reg;
        dist_next   = dist_reg;
        first_next  = first_reg;
        chosen_next = chosen_reg;
        cnt_next    = cnt_reg;
        cidx_next   = cidx_reg;
        jv_next     = jv_reg && !job_ready;
        job_next    = job_reg;
        if (accept)
        begin
            if (start_reg)
            begin
                speed_next = speed;
                dist_next  = d_cl;
                first_next = point_y;
            end
            start_next = last_point;
            found_next = found_use || hit;
            if (hit)
            begin
                chosen_next = point_y;
                cidx_next   = cnt_use;
            end
            cnt_next = (cnt_use < IDX_CAP) ? cnt_use + 10'd1 : cnt_use;
            if (last_point)
            begin
                jv_next         = 1'b1;
                job_next.lateral = start_reg ? point_y : first_reg;
                job_next.speed   = start_reg ? speed : speed_reg;
                if (found_use)
                begin
                    job_next.chosen = chosen_reg;
                    job_next.index  = cidx_reg;
                end
                else
                begin
                    job_next.chosen = point_y;
                    job_next.index  = cnt_use;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 1'b1;
            found_reg  <= 1'b0;
            speed_reg  <= '0;
            dist_reg   <= '0;
            first_reg  <= '0;
            chosen_reg <= '0;
            cnt_reg    <= '0;
            cidx_reg   <= '0;
            jv_reg     <= 1'b0;
        end
        else
        begin
            start_reg  <= start_next;
            found_reg  <= found_next;
            speed_reg  <= speed_next;
            dist_reg   <= dist_next;
            first_reg  <= first_next;
            chosen_reg <= chosen_next;
            cnt_reg    <= cnt_next;
            cidx_reg   <= cidx_next;
            jv_reg     <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

`include "assert_macros.svh"
    `ASSERT_IMPLIES(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= IDX_CAP)
    `ASSERT_NEXT(a_job_hold, clk, rst_n, jv_reg && !job_ready, jv_reg && $stable(job_reg))
    `ASSERT_NEXT(a_last_restart, clk, rst_n, accept && last_point, start_reg)
endmodule

// ===== rtl/lls_back.sv =====
// Back part: turns one job into a steering command with separate multipliers
// and a bit-serial divider. Depends on lls_pkg.
`timescale 1ns / 1ps
module lls_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  lls_pkg::job_t      job,
    input  lls_pkg::back_cfg_t cfg,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [105:0]       out_data
);
    lls_pkg::back_state_t state_reg, state_next;
    lls_pkg::job_t        job_reg;
    logic                 neg_reg;
    logic [45:0]          b_reg;
    logic [61:0]          rem_reg;
    logic [61:0]          quo_reg;
    logic [5:0]           bit_reg;
    logic [31:0]          steer_reg;
    logic [63:0]          dividend;

    logic [31:0]          err_mag;
    logic [56:0]          pa;
    logic [65:0]          pb;
    logic [62:0]          rem_sh;
    logic [63:0]          d_full;

    always_comb
    begin
        err_mag  = job_reg.chosen[31] ? 32'(-job_reg.chosen) : 32'(job_reg.chosen);
        pa       = {25'd0, err_mag} * {32'd0, cfg.gain};
        pb       = {20'd0, b_reg} * {45'd0, cfg.wheel_base};
        dividend = {2'd0, b_reg, 16'd0};
        rem_sh   = {rem_reg, dividend[bit_reg]};
        d_full   = {34'd0, b_reg[45:16]} * {41'd0, cfg.steer_ratio}
                 + {33'd0, 31'(({39'd0, b_reg[15:0]} * {32'd0, cfg.steer_ratio}) >> 16)};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lls_pkg::ST_IDLE:  if (job_valid) state_next = lls_pkg::ST_MUL_A;
            lls_pkg::ST_MUL_A: state_next = lls_pkg::ST_MUL_B;
            lls_pkg::ST_MUL_B: state_next = (job_reg.speed > lls_pkg::ONE_Q16)
                                          ? lls_pkg::ST_DIV : lls_pkg::ST_MUL_D;
            lls_pkg::ST_DIV:   if (bit_reg == 6'd0) state_next = lls_pkg::ST_MUL_D;
            lls_pkg::ST_MUL_D: state_next = lls_pkg::ST_DONE;
            lls_pkg::ST_DONE:  if (out_ready) state_next = lls_pkg::ST_IDLE;
            default:           state_next = lls_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            lls_pkg::ST_IDLE: job_ready = 1'b1;
            lls_pkg::ST_DONE: out_valid = 1'b1;
            default:          job_ready = 1'b0;
        endcase
    end

    assign out_data = {job_reg.index, job_reg.chosen, job_reg.lateral, steer_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lls_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lls_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg <= job;
                end
            end
            lls_pkg::ST_MUL_A:
            begin
                b_reg   <= {5'd0, pa[56:16]};
                neg_reg <= (job_reg.chosen > 0) ^ cfg.invert;
            end
            lls_pkg::ST_MUL_B:
            begin
                b_reg   <= pb[61:16];
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= 6'd63;
            end
            lls_pkg::ST_DIV:
            begin
                if (rem_sh >= {38'd0, job_reg.speed})
                begin
                    rem_reg <= 62'(rem_sh - {38'd0, job_reg.speed});
                    quo_reg <= {quo_reg[60:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[61:0];
                    quo_reg <= {quo_reg[60:0], 1'b0};
                end
                bit_reg <= bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    if (rem_sh >= {38'd0, job_reg.speed})
                    begin
                        b_reg <= 46'({quo_reg[60:0], 1'b1});
                    end
                    else
                    begin
                        b_reg <= 46'({quo_reg[60:0], 1'b0});
                    end
                end
            end
            lls_pkg::ST_MUL_D:
            begin
                if (neg_reg)
                begin
                    steer_reg <= (d_full >= 64'h8000_0000) ? 32'h8000_0000
                               : 32'(-d_full);
                end
                else
                begin
                    steer_reg <= (d_full >= 64'h8000_0000) ? 32'h7FFF_FFFF
                               : d_full[31:0];
                end
            end
            default:
            begin
                steer_reg <= steer_reg;
            end
        endcase
    end

`include "assert_macros.svh"
    `ASSERT_IMPLIES(a_excl, clk, rst_n, 1'b1, !(job_ready && out_valid))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(steer_reg))
    `ASSERT_NEXT(a_start, clk, rst_n, job_valid && job_ready, state_reg == lls_pkg::ST_MUL_A)
endmodule

// ===== rtl/lls_cfg.sv =====
// APB register file for the steering controller settings.
// Depends on lls_pkg.
`timescale 1ns / 1ps
module lls_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [24:0]        min_la,
    output logic [24:0]        max_la,
    output logic [24:0]        ratio,
    output lls_pkg::back_cfg_t bcfg
);
    logic [24:0] min_reg, max_reg, ratio_reg, gain_reg;
    logic [20:0] wb_reg;
    logic [22:0] sr_reg;
    logic        inv_reg;
    logic        wr;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0; max_reg <= '0; ratio_reg <= '0; gain_reg <= '0;
            wb_reg <= '0; sr_reg <= '0; inv_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                lls_pkg::REG_MIN_LA: min_reg   <= pwdata[24:0];
                lls_pkg::REG_MAX_LA: max_reg   <= pwdata[24:0];
                lls_pkg::REG_RATIO:  ratio_reg <= pwdata[24:0];
                lls_pkg::REG_GAIN:   gain_reg  <= pwdata[24:0];
                lls_pkg::REG_WBASE:  wb_reg    <= pwdata[20:0];
                lls_pkg::REG_SRATIO: sr_reg    <= pwdata[22:0];
                lls_pkg::REG_INVERT: inv_reg   <= pwdata[0];
                default:             inv_reg   <= inv_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            lls_pkg::REG_MIN_LA: prdata = {7'd0, min_reg};
            lls_pkg::REG_MAX_LA: prdata = {7'd0, max_reg};
            lls_pkg::REG_RATIO:  prdata = {7'd0, ratio_reg};
            lls_pkg::REG_GAIN:   prdata = {7'd0, gain_reg};
            lls_pkg::REG_WBASE:  prdata = {11'd0, wb_reg};
            lls_pkg::REG_SRATIO: prdata = {9'd0, sr_reg};
            lls_pkg::REG_INVERT: prdata = {31'd0, inv_reg};
            default:             prdata = '0;
        endcase
    end

    assign min_la = min_reg;
    assign max_la = max_reg;
    assign ratio  = ratio_reg;
    assign bcfg   = '{gain: gain_reg, wheel_base: wb_reg, steer_ratio: sr_reg,
                      invert: inv_reg};
endmodule

// ===== rtl/lookahead_lateral_steer_top.sv =====
// Channel   Dir  Contents
// s_axis    in   tdata {point_y, point_x}, tuser speed, tlast last_point
// m_axis    out  tdata {index, lookahead_error, lateral_error, steer}
// apb       in   seven setting registers at 4*i
// Points are taken one a cycle unless intake stalls; the last point of a path hands a
// job to the back part, which steps through MUL_A, MUL_B, the bit-serial divider
// when the held speed exceeds 1.0, then MUL_D and DONE, and takes no new job until
// its result is taken. One job waits between the parts; while it waits and the back
// part is busy, point intake stalls. Output stalls hold DONE. Reset is asynchronous.
`timescale 1ns / 1ps
module lookahead_lateral_steer_top #(
    parameter int MAX_POINTS = lls_pkg::MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // point_x [31:0], point_y [63:32]
    input  logic [24:0]  s_axis_tuser,  // speed [24:0]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // steer, lateral_error, lookahead_error, index
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [24:0]        min_la, max_la, ratio;
    lls_pkg::back_cfg_t bcfg;
    logic               job_valid, job_ready;
    lls_pkg::job_t      job;
    logic [105:0]       out_data;

    lls_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .min_la(min_la), .max_la(max_la), .ratio(ratio), .bcfg(bcfg)
    );

    lls_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .point_x(s_axis_tdata[31:0]), .point_y(s_axis_tdata[63:32]),
        .speed(s_axis_tuser), .last_point(s_axis_tlast),
        .min_la(min_la), .max_la(max_la), .ratio(ratio),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    lls_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
        .job(job), .cfg(bcfg), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(out_data)
    );

    assign m_axis_tdata = {6'd0, out_data};
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for lookahead_lateral_steer_top.
// Streams paths of points, predicts each steering result or takes it from a table, and
// compares every field; depends on lls_pkg and the RTL of the controller only.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic signed [31:0] steer;
        logic signed [31:0] lateral;
        logic signed [31:0] chosen;
        logic [9:0]         index;
    } steer_res_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [24:0] spd;
        logic        last;
        logic        typed;
        steer_res_t  res;
    } point_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;   // point_x [31:0], point_y [63:32]
    logic [24:0]  s_axis_tuser;   // speed [24:0]
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // steer, lateral_error, lookahead_error, index
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    lookahead_lateral_steer_top dut (.*);

    logic [63:0] c_min, c_max, c_ratio, c_gain, c_wbase, c_sratio, c_inv;
    logic        at_start, found;
    logic [63:0] held_spd, la_dist;
    logic [31:0] first_y, chosen_y;
    logic [9:0]  pt_count, chosen_idx;

    steer_res_t  pending_steer[$];
    int          mismatches;
    int          snd_idle;
    int          rcv_idle;
    int          items;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [31:0] steer_of(logic [31:0] err);
        logic        neg;
        logic [63:0] e, a, b, d;
        neg = $signed(err) > 0;
        e = $signed(err) < 0 ? 64'(-$signed({32'hffffffff, err})) : {32'd0, err};
        a = (c_gain * e) >> 16;
        b = (a * c_wbase) >> 16;
        if (held_spd > 64'(lls_pkg::ONE_Q16))
            b = (b << 16) / held_spd;
        d = (b >> 16) * c_sratio + (((b & 64'hffff) * c_sratio) >> 16);
        if (c_inv[0])
            neg = !neg;
        if (neg)
            return d >= 64'h80000000 ? 32'h80000000 : 32'(-$signed(d));
        return d >= 64'h80000000 ? 32'h7fffffff : d[31:0];
    endfunction

    // Returns 1 and fills res when the point closes a path.
    function automatic logic track_point(logic [31:0] x, logic [31:0] y, logic [24:0] spd,
                                         logic last, output steer_res_t res);
        logic [63:0] d;
        if (at_start)
        begin
            held_spd = {39'd0, spd};
            d = (held_spd * c_ratio) >> 16;
            if (d > c_max)
                d = c_max;
            if (d < c_min)
                d = c_min;
            la_dist = d;
            first_y = y;
            pt_count = '0;
            found = 1'b0;
            at_start = 1'b0;
        end
        if (!found && longint'($signed(x)) > longint'(la_dist))
        begin
            found = 1'b1;
            chosen_y = y;
            chosen_idx = pt_count;
        end
        if (!last)
        begin
            if (pt_count < 10'd1023)
                pt_count++;
            return 1'b0;
        end
        if (!found)
        begin
            chosen_y = y;
            chosen_idx = pt_count;
        end
        res.steer = steer_of(chosen_y);
        res.lateral = first_y;
        res.chosen = chosen_y;
        res.index = chosen_idx;
        at_start = 1'b1;
        return 1'b1;
    endfunction

    task automatic write_reg(lls_pkg::reg_idx_t idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            lls_pkg::REG_MIN_LA: c_min = 64'(val & 32'h1ffffff);
            lls_pkg::REG_MAX_LA: c_max = 64'(val & 32'h1ffffff);
            lls_pkg::REG_RATIO:  c_ratio = 64'(val & 32'h1ffffff);
            lls_pkg::REG_GAIN:   c_gain = 64'(val & 32'h1ffffff);
            lls_pkg::REG_WBASE:  c_wbase = 64'(val & 32'h1fffff);
            lls_pkg::REG_SRATIO: c_sratio = 64'(val & 32'h7fffff);
            default:             c_inv = 64'(val & 32'h1);
        endcase
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [24:0] spd, logic last,
                              logic typed, steer_res_t typed_res);
        steer_res_t r;
        while ($urandom_range(99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        s_axis_tuser <= spd;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (track_point(x, y, spd, last, r))
            pending_steer.push_back(typed ? typed_res : r);
        items++;
        @(negedge clk);
    endtask

    task automatic drain;
        int n;
        s_axis_tvalid <= 1'b0;
        while (pending_steer.size() != 0)
            @(negedge clk);
        for (n = 0; n < 120; n++)
            @(negedge clk);
    endtask

    task automatic send_path(int len);
        int          k;
        logic [24:0] spd;
        logic [31:0] x;
        steer_res_t  none;
        none = '0;
        case ($urandom_range(4))
            0: spd = 25'd0;
            1: spd = 25'd65536;
            2: spd = 25'd65537;
            3: spd = 25'($urandom_range(262144));
            default: spd = 25'($urandom);
        endcase
        for (k = 0; k < len; k++)
        begin
            x = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1 << 21)) - 32'd4096;
            send_point(x, $urandom, spd, k == len - 1, 1'b0, none);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= $urandom_range(99) >= rcv_idle;

    always @(posedge clk)
    begin
        steer_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.steer = m_axis_tdata[31:0];
            got.lateral = m_axis_tdata[63:32];
            got.chosen = m_axis_tdata[95:64];
            got.index = m_axis_tdata[105:96];
            if (pending_steer.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_steer.pop_front();
                if (got !== want || m_axis_tdata[111:106] !== 6'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected steer %h lat %h la %h idx %0d, got %h %h %h %0d",
                                 want.steer, want.lateral, want.chosen, want.index,
                                 got.steer, got.lateral, got.chosen, got.index);
                end
            end
        end
    end

    point_row_t rows[] = '{
        '{32'd1, 32'd5, 25'd0, 1'b1, 1'b1, '{32'd0, 32'd5, 32'd5, 10'd0}},
        '{32'd0, 32'hfffffff9, 25'd0, 1'b1, 1'b1, '{32'd0, 32'hfffffff9, 32'hfffffff9, 10'd0}},
        '{32'h80000000, 32'h7fffffff, 25'h1ffffff, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'h7fffffff, 32'h80000000, 25'd0, 1'b1, 1'b1,
          '{32'd0, 32'h7fffffff, 32'h80000000, 10'd1}},
        '{32'h7fffffff, 32'h80000000, 25'h1000000, 1'b1, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'd0, 32'h7fffffff, 25'd65536, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'h7fffffff, 32'h00010000, 25'd0, 1'b1, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'd5, 32'h00020000, 25'd65537, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'h80000000, 32'hffff0000, 25'd0, 1'b0, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'h01000001, 32'hfffffffe, 25'd0, 1'b1, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'd0, 32'd1, 25'd1, 1'b1, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}},
        '{32'd0, 32'hffffffff, 25'd0, 1'b1, 1'b0, '{32'd0, 32'd0, 32'd0, 10'd0}}
    };

    initial
    begin
        int p, k, target;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        {c_min, c_max, c_ratio, c_gain, c_wbase, c_sratio, c_inv} = '0;
        at_start = 1'b1;
        found = 1'b0;
        held_spd = '0;
        la_dist = '0;
        first_y = '0;
        chosen_y = '0;
        pt_count = '0;
        chosen_idx = '0;
        mismatches = 0;
        items = 0;
        snd_idle = 19;
        rcv_idle = 71;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < rows.size(); k++)
        begin
            if (k == 4)
            begin
                drain();
                write_reg(lls_pkg::REG_MIN_LA, 32'h1000000);
                write_reg(lls_pkg::REG_MAX_LA, 32'h1000000);
                write_reg(lls_pkg::REG_RATIO, 32'h1000000);
                write_reg(lls_pkg::REG_GAIN, 32'h1000000);
                write_reg(lls_pkg::REG_WBASE, 32'h100000);
                write_reg(lls_pkg::REG_SRATIO, 32'h400000);
                write_reg(lls_pkg::REG_INVERT, 32'd1);
            end
            send_point(rows[k].x, rows[k].y, rows[k].spd, rows[k].last,
                       rows[k].typed, rows[k].res);
        end

        for (p = 0; p < 6; p++)
        begin
            drain();
            snd_idle = p < 2 ? 19 : (p < 4 ? 71 : 0);
            rcv_idle = p < 2 ? 71 : (p < 4 ? 19 : 0);
            if (p == 1)
            begin
                write_reg(lls_pkg::REG_MIN_LA, 32'd0);
                write_reg(lls_pkg::REG_MAX_LA, 32'd0);
                write_reg(lls_pkg::REG_RATIO, 32'd0);
                write_reg(lls_pkg::REG_GAIN, 32'd1);
                write_reg(lls_pkg::REG_WBASE, 32'd0);
                write_reg(lls_pkg::REG_SRATIO, 32'd1);
                write_reg(lls_pkg::REG_INVERT, 32'd0);
            end
            else
            begin
                write_reg(lls_pkg::REG_MIN_LA, $urandom_range(1 << 20));
                write_reg(lls_pkg::REG_MAX_LA, $urandom_range(1 << 24));
                write_reg(lls_pkg::REG_RATIO, $urandom_range(1 << 24) >> $urandom_range(8));
                write_reg(lls_pkg::REG_GAIN, $urandom_range(1 << 24) >> $urandom_range(8));
                write_reg(lls_pkg::REG_WBASE, $urandom_range(1 << 20));
                write_reg(lls_pkg::REG_SRATIO, $urandom_range(1 << 22));
                write_reg(lls_pkg::REG_INVERT, $urandom_range(1));
            end
            if (p == 4)
                send_path(1030);
            target = items + 135;
            while (items < target)
                send_path($urandom_range(9) == 0 ? $urandom_range(40, 12) : $urandom_range(6, 1));
        end
        drain();

        if (mismatches == 0 && pending_steer.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
